// ===== design/edmonds_karp_max_flow_unit_defines.svh =====
// Assertion macros for the max-flow unit.
`ifndef EDMONDS_KARP_MAX_FLOW_UNIT_DEFINES_SVH
`define EDMONDS_KARP_MAX_FLOW_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define EKMF_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define EKMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define EKMF_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define EKMF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/ekmf_pkg.sv =====
package ekmf_pkg;

   localparam int NODES_DEF = 64;
   localparam int EDGES_DEF = 256;

   localparam int NODE_FW = 6;
   localparam int CAP_W   = 16;
   localparam int IDX_W   = 8;
   localparam int VAL_W   = 24;
   localparam int RES_W   = 17;
   localparam int CSR_IDX_W = 1;

   localparam logic [RES_W-1:0] RES_MAX = '1;
   localparam logic [VAL_W-1:0] VAL_MAX = '1;

   localparam logic [NODE_FW-1:0] SOURCE_RST = 6'd0;
   localparam logic [NODE_FW-1:0] SINK_RST   = 6'd63;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_RUN   = 2'd1,
      REQ_READ  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE = 1'b0,
      CSR_SINK   = 1'b1
   } csr_reg_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_EDGE,
      ST_RD_RES,
      ST_BFS_INIT,
      ST_POP,
      ST_POP_WAIT,
      ST_SCAN,
      ST_SCAN_EDGE,
      ST_SCAN_RES,
      ST_NECK_PAR,
      ST_NECK_PW,
      ST_NECK_RES,
      ST_AUG_PAR,
      ST_AUG_PW,
      ST_AUG_F1,
      ST_AUG_F2,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic               status;
      logic [VAL_W-1:0]   value;
      logic [NODE_FW-1:0] edge_from;
      logic [NODE_FW-1:0] edge_to;
   } rsp_type;

   typedef struct packed {
      logic ready;
      logic done;
   } ctl_flags_type;

endpackage

// ===== design/ekmf_ram.sv =====
module ekmf_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [(1 << ADDR_W)];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== design/ekmf_ctrl.sv =====
module ekmf_ctrl #(
   parameter int NODES = ekmf_pkg::NODES_DEF,
   parameter int EDGES = ekmf_pkg::EDGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [1:0]                      req_type,
   input  logic [ekmf_pkg::NODE_FW-1:0]    req_from_node,
   input  logic [ekmf_pkg::NODE_FW-1:0]    req_to_node,
   input  logic [ekmf_pkg::CAP_W-1:0]      req_capacity,
   input  logic [ekmf_pkg::IDX_W-1:0]      req_edge_index,
   input  logic [ekmf_pkg::NODE_FW-1:0]    src_node,
   input  logic [ekmf_pkg::NODE_FW-1:0]    snk_node,
   input  logic                            rsp_free,
   output ekmf_pkg::ctl_flags_type         flags,
   output ekmf_pkg::rsp_type               result
);

   localparam int NW  = $clog2(NODES);
   localparam int EW  = (EDGES > 1) ? $clog2(EDGES) : 1;
   localparam int CW  = $clog2(EDGES + 1);
   localparam int RAW = 2 * NW;
   localparam int QW  = NW + 1;
   localparam int RW  = ekmf_pkg::RES_W;
   localparam int VW  = ekmf_pkg::VAL_W;

   ekmf_pkg::ctl_state_type state_ff, state_in;
   logic [RAW-1:0]   clr_addr_ff, clr_addr_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    e_ff, e_in;
   logic [NODES-1:0] visited_ff, visited_in;
   logic [QW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0]    u_ff, u_in, v_ff, v_in;
   logic [RW-1:0]    neck_ff, neck_in;
   logic [VW-1:0]    total_ff, total_in;
   ekmf_pkg::rsp_type rsp_ff, rsp_in;

   logic            res_we, res_re;
   logic [RAW-1:0]  res_waddr, res_raddr;
   logic [RW-1:0]   res_wdata, res_rdata;
   logic            edg_we, edg_re;
   logic [EW-1:0]   edg_waddr, edg_raddr;
   logic [RAW-1:0]  edg_wdata, edg_rdata;
   logic            par_we, par_re;
   logic [NW-1:0]   par_waddr, par_raddr, par_wdata, par_rdata;
   logic            que_we, que_re;
   logic [NW-1:0]   que_waddr, que_raddr, que_wdata, que_rdata;

   ekmf_pkg::req_code_type req_code;
   logic [NW-1:0] a_n, b_n, src_n, snk_n, edg_ta, edg_hd, cand_v;
   logic add_bad, run_bad, read_bad, clr_last;
   logic cand_fwd, cand_bwd, cand_ok, scan_more, q_nonempty, visit_ok;
   logic [RW:0]   back_sum;
   logic [VW:0]   total_sum;

   assign req_code   = ekmf_pkg::req_code_type'(req_type);
   assign a_n        = NW'(req_from_node);
   assign b_n        = NW'(req_to_node);
   assign src_n      = NW'(src_node);
   assign snk_n      = NW'(snk_node);
   assign add_bad    = (32'(count_ff) >= EDGES) || (32'(req_from_node) >= NODES) ||
                       (32'(req_to_node) >= NODES);
   assign run_bad    = (32'(src_node) >= NODES) || (32'(snk_node) >= NODES);
   assign read_bad   = 32'(req_edge_index) >= 32'(count_ff);
   assign clr_last   = &clr_addr_ff;
   assign edg_ta     = edg_rdata[RAW-1:NW];
   assign edg_hd     = edg_rdata[NW-1:0];
   // self loops never yield a neighbor: the popped node is always visited
   assign cand_fwd   = (edg_ta == u_ff) && (edg_hd != u_ff);
   assign cand_bwd   = (edg_hd == u_ff) && (edg_ta != u_ff);
   assign cand_v     = cand_fwd ? edg_hd : edg_ta;
   assign cand_ok    = (cand_fwd || cand_bwd) && !visited_ff[cand_v];
   assign scan_more  = e_ff < count_ff;
   assign q_nonempty = head_ff < tail_ff;
   assign visit_ok   = (res_rdata != '0) && (32'(tail_ff) < NODES);
   assign back_sum   = (RW+1)'(res_rdata) + (RW+1)'(neck_ff);
   assign total_sum  = (VW+1)'(total_ff) + (VW+1)'(neck_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ekmf_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = clr_rsp_ff ? ekmf_pkg::ST_DONE : ekmf_pkg::ST_IDLE;
            end
         end
         ekmf_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_code)
                  ekmf_pkg::REQ_ADD:   state_in = ekmf_pkg::ST_DONE;
                  ekmf_pkg::REQ_RUN: begin
                     state_in = (run_bad || src_n == snk_n) ? ekmf_pkg::ST_DONE
                                                              : ekmf_pkg::ST_BFS_INIT;
                  end
                  ekmf_pkg::REQ_READ: begin
                     state_in = read_bad ? ekmf_pkg::ST_DONE : ekmf_pkg::ST_RD_EDGE;
                  end
                  ekmf_pkg::REQ_CLEAR: state_in = ekmf_pkg::ST_CLEAR;
                  default:             state_in = ekmf_pkg::ST_DONE;
               endcase
            end
         end
         ekmf_pkg::ST_RD_EDGE:  state_in = ekmf_pkg::ST_RD_RES;
         ekmf_pkg::ST_RD_RES:   state_in = ekmf_pkg::ST_DONE;
         ekmf_pkg::ST_BFS_INIT: state_in = ekmf_pkg::ST_POP;
         ekmf_pkg::ST_POP: begin
            state_in = q_nonempty ? ekmf_pkg::ST_POP_WAIT : ekmf_pkg::ST_DONE;
         end
         ekmf_pkg::ST_POP_WAIT: begin
            state_in = (que_rdata == snk_n) ? ekmf_pkg::ST_NECK_PAR : ekmf_pkg::ST_SCAN;
         end
         ekmf_pkg::ST_SCAN: begin
            state_in = scan_more ? ekmf_pkg::ST_SCAN_EDGE : ekmf_pkg::ST_POP;
         end
         ekmf_pkg::ST_SCAN_EDGE: begin
            state_in = cand_ok ? ekmf_pkg::ST_SCAN_RES : ekmf_pkg::ST_SCAN;
         end
         ekmf_pkg::ST_SCAN_RES: state_in = ekmf_pkg::ST_SCAN;
         ekmf_pkg::ST_NECK_PAR: state_in = ekmf_pkg::ST_NECK_PW;
         ekmf_pkg::ST_NECK_PW:  state_in = ekmf_pkg::ST_NECK_RES;
         ekmf_pkg::ST_NECK_RES: begin
            state_in = (u_ff == src_n) ? ekmf_pkg::ST_AUG_PAR : ekmf_pkg::ST_NECK_PAR;
         end
         ekmf_pkg::ST_AUG_PAR: state_in = ekmf_pkg::ST_AUG_PW;
         ekmf_pkg::ST_AUG_PW:  state_in = ekmf_pkg::ST_AUG_F1;
         ekmf_pkg::ST_AUG_F1:  state_in = ekmf_pkg::ST_AUG_F2;
         ekmf_pkg::ST_AUG_F2: begin
            state_in = (u_ff == src_n) ? ekmf_pkg::ST_BFS_INIT : ekmf_pkg::ST_AUG_PAR;
         end
         ekmf_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = ekmf_pkg::ST_IDLE;
            end
         end
         default: state_in = ekmf_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_rsp_in  = clr_rsp_ff;
      count_in    = count_ff;
      e_in        = e_ff;
      visited_in  = visited_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      neck_in     = neck_ff;
      total_in    = total_ff;
      rsp_in      = rsp_ff;
      res_we = 1'b0; res_waddr = '0; res_wdata = '0; res_re = 1'b0; res_raddr = '0;
      edg_we = 1'b0; edg_waddr = '0; edg_wdata = '0; edg_re = 1'b0; edg_raddr = '0;
      par_we = 1'b0; par_waddr = '0; par_wdata = '0; par_re = 1'b0; par_raddr = '0;
      que_we = 1'b0; que_waddr = '0; que_wdata = '0; que_re = 1'b0; que_raddr = '0;
      case (state_ff)
         ekmf_pkg::ST_CLEAR: begin
            res_we      = 1'b1;
            res_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ekmf_pkg::ST_IDLE: begin
            if (req_valid) begin
               rsp_in = '0;
               case (req_code)
                  ekmf_pkg::REQ_ADD: begin
                     if (add_bad) begin
                        rsp_in.status = 1'b1;
                     end else begin
                        res_we    = 1'b1;
                        res_waddr = {a_n, b_n};
                        res_wdata = RW'(req_capacity);
                        edg_we    = 1'b1;
                        edg_waddr = EW'(count_ff);
                        edg_wdata = {a_n, b_n};
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  ekmf_pkg::REQ_RUN: begin
                     rsp_in.status = run_bad;
                     total_in      = '0;
                  end
                  ekmf_pkg::REQ_READ: begin
                     if (read_bad) begin
                        rsp_in.status = 1'b1;
                     end else begin
                        edg_re    = 1'b1;
                        edg_raddr = EW'(req_edge_index);
                     end
                  end
                  ekmf_pkg::REQ_CLEAR: begin
                     count_in    = '0;
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                  end
                  default: rsp_in = '0;
               endcase
            end
         end
         ekmf_pkg::ST_RD_EDGE: begin
            rsp_in.edge_from = ekmf_pkg::NODE_FW'(edg_ta);
            rsp_in.edge_to   = ekmf_pkg::NODE_FW'(edg_hd);
            res_re    = 1'b1;
            res_raddr = {edg_hd, edg_ta};
         end
         ekmf_pkg::ST_RD_RES: begin
            rsp_in.value = VW'(res_rdata);
         end
         ekmf_pkg::ST_BFS_INIT: begin
            visited_in        = '0;
            visited_in[src_n] = 1'b1;
            par_we    = 1'b1;
            par_waddr = src_n;
            par_wdata = src_n;
            que_we    = 1'b1;
            que_waddr = '0;
            que_wdata = src_n;
            head_in   = '0;
            tail_in   = QW'(1);
         end
         ekmf_pkg::ST_POP: begin
            if (q_nonempty) begin
               que_re    = 1'b1;
               que_raddr = head_ff[NW-1:0];
               head_in   = head_ff + 1'b1;
            end else begin
               rsp_in.value = total_ff;
            end
         end
         ekmf_pkg::ST_POP_WAIT: begin
            u_in    = que_rdata;
            e_in    = '0;
            v_in    = snk_n;
            neck_in = ekmf_pkg::RES_MAX;
         end
         ekmf_pkg::ST_SCAN: begin
            if (scan_more) begin
               edg_re    = 1'b1;
               edg_raddr = EW'(e_ff);
               e_in      = e_ff + 1'b1;
            end
         end
         ekmf_pkg::ST_SCAN_EDGE: begin
            if (cand_ok) begin
               res_re    = 1'b1;
               res_raddr = {u_ff, cand_v};
               v_in      = cand_v;
            end
         end
         ekmf_pkg::ST_SCAN_RES: begin
            if (visit_ok) begin
               visited_in[v_ff] = 1'b1;
               par_we    = 1'b1;
               par_waddr = v_ff;
               par_wdata = u_ff;
               que_we    = 1'b1;
               que_waddr = tail_ff[NW-1:0];
               que_wdata = v_ff;
               tail_in   = tail_ff + 1'b1;
            end
         end
         ekmf_pkg::ST_NECK_PAR, ekmf_pkg::ST_AUG_PAR: begin
            par_re    = 1'b1;
            par_raddr = v_ff;
         end
         ekmf_pkg::ST_NECK_PW, ekmf_pkg::ST_AUG_PW: begin
            u_in      = par_rdata;
            res_re    = 1'b1;
            res_raddr = {par_rdata, v_ff};
         end
         ekmf_pkg::ST_NECK_RES: begin
            if (res_rdata < neck_ff) begin
               neck_in = res_rdata;
            end
            // path walked back to the source: restart from the sink for the update
            v_in = (u_ff == src_n) ? snk_n : u_ff;
         end
         ekmf_pkg::ST_AUG_F1: begin
            res_we    = 1'b1;
            res_waddr = {u_ff, v_ff};
            res_wdata = res_rdata - neck_ff;
            res_re    = 1'b1;
            res_raddr = {v_ff, u_ff};
         end
         ekmf_pkg::ST_AUG_F2: begin
            res_we    = 1'b1;
            res_waddr = {v_ff, u_ff};
            res_wdata = back_sum[RW] ? ekmf_pkg::RES_MAX : back_sum[RW-1:0];
            v_in      = u_ff;
            if (u_ff == src_n) begin
               total_in = total_sum[VW] ? ekmf_pkg::VAL_MAX : total_sum[VW-1:0];
            end
         end
         ekmf_pkg::ST_DONE: begin
            rsp_in = rsp_ff;
         end
         default: rsp_in = rsp_ff;
      endcase
   end

   // flags
   always_comb begin
      flags.ready = (state_ff == ekmf_pkg::ST_IDLE);
      flags.done  = (state_ff == ekmf_pkg::ST_DONE) && rsp_free;
   end

   assign result = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ekmf_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         clr_rsp_ff  <= 1'b0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         clr_rsp_ff  <= clr_rsp_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff       <= e_in;
      visited_ff <= visited_in;
      head_ff    <= head_in;
      tail_ff    <= tail_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      neck_ff    <= neck_in;
      total_ff   <= total_in;
      rsp_ff     <= rsp_in;
   end

   ekmf_ram #(.WIDTH(RW), .ADDR_W(RAW)) u_residual (
      .clock   (clock),
      .wr_en   (res_we),
      .wr_addr (res_waddr),
      .wr_data (res_wdata),
      .rd_en   (res_re),
      .rd_addr (res_raddr),
      .rd_data (res_rdata)
   );

   ekmf_ram #(.WIDTH(RAW), .ADDR_W(EW)) u_edges (
      .clock   (clock),
      .wr_en   (edg_we),
      .wr_addr (edg_waddr),
      .wr_data (edg_wdata),
      .rd_en   (edg_re),
      .rd_addr (edg_raddr),
      .rd_data (edg_rdata)
   );

   ekmf_ram #(.WIDTH(NW), .ADDR_W(NW)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_en   (par_re),
      .rd_addr (par_raddr),
      .rd_data (par_rdata)
   );

   ekmf_ram #(.WIDTH(NW), .ADDR_W(NW)) u_queue (
      .clock   (clock),
      .wr_en   (que_we),
      .wr_addr (que_waddr),
      .wr_data (que_wdata),
      .rd_en   (que_re),
      .rd_addr (que_raddr),
      .rd_data (que_rdata)
   );

endmodule

// ===== design/edmonds_karp_max_flow_unit.sv =====
// Max-flow engine over a directed graph held in a residual-capacity RAM.
// Requests come in on req_* (valid/ready): add edge, run max flow, read edge
// flow, clear graph. Each request gives exactly one beat on rsp_* (valid/ready).
// source and sink are set through the csr_* write port; the user must write
// them only while the unit is idle, the block itself does not enforce this.
// A clear request rewrites every residual RAM entry before its result beat.
// A run is data dependent: each search scans the edge list for each node popped
// from the queue, then walks the path back for the bottleneck and the update.
// One request is worked on at a time; req_ready drops while busy.
// Reset starts a clearing pass over the residual RAM, one entry per cycle
// (4096 entries by default), during which no request is taken.
// The result sits in an output register; the next request is accepted while
// it waits, but a finished result is held back until rsp_ready frees the slot.
`include "edmonds_karp_max_flow_unit_defines.svh"

module edmonds_karp_max_flow_unit #(
   parameter int NODES = ekmf_pkg::NODES_DEF,
   parameter int EDGES = ekmf_pkg::EDGES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [ekmf_pkg::NODE_FW-1:0]        req_from_node,
   input  logic [ekmf_pkg::NODE_FW-1:0]        req_to_node,
   input  logic [ekmf_pkg::CAP_W-1:0]          req_capacity,
   input  logic [ekmf_pkg::IDX_W-1:0]          req_edge_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_status,
   output logic [ekmf_pkg::VAL_W-1:0]          rsp_value,
   output logic [ekmf_pkg::NODE_FW-1:0]        rsp_edge_from,
   output logic [ekmf_pkg::NODE_FW-1:0]        rsp_edge_to,
   input  logic                                csr_wr_en,
   input  logic [ekmf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ekmf_pkg::NODE_FW-1:0]        csr_wdata
);

   logic [ekmf_pkg::NODE_FW-1:0] src_ff, src_in, snk_ff, snk_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ekmf_pkg::rsp_type            out_ff, out_in;
   ekmf_pkg::rsp_type            result;
   ekmf_pkg::ctl_flags_type      flags;
   logic                         rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      src_in = src_ff;
      snk_in = snk_ff;
      if (csr_wr_en) begin
         case (ekmf_pkg::csr_reg_type'(csr_index))
            ekmf_pkg::CSR_SOURCE: src_in = csr_wdata;
            ekmf_pkg::CSR_SINK:   snk_in = csr_wdata;
            default:              src_in = src_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_in       = out_ff;
      if (flags.done) begin
         rsp_valid_in = 1'b1;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff       <= ekmf_pkg::SOURCE_RST;
         snk_ff       <= ekmf_pkg::SINK_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_ff       <= src_in;
         snk_ff       <= snk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   ekmf_ctrl #(.NODES(NODES), .EDGES(EDGES)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_type       (req_type),
      .req_from_node  (req_from_node),
      .req_to_node    (req_to_node),
      .req_capacity   (req_capacity),
      .req_edge_index (req_edge_index),
      .src_node       (src_ff),
      .snk_node       (snk_ff),
      .rsp_free       (rsp_free),
      .flags          (flags),
      .result         (result)
   );

   assign req_ready     = flags.ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = out_ff.status;
   assign rsp_value     = out_ff.value;
   assign rsp_edge_from = out_ff.edge_from;
   assign rsp_edge_to   = out_ff.edge_to;

   `EKMF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `EKMF_ASSERT_IMPLY(a_done_needs_slot, clock, reset, flags.done, !rsp_valid_ff || rsp_ready)
   `EKMF_ASSERT_NEXT(a_done_shows_beat, clock, reset, flags.done, rsp_valid)

endmodule

// ===== tb/edmonds_karp_max_flow_unit_test.sv =====
module edmonds_karp_max_flow_unit_test;

   localparam int N = 64;
   localparam int E = 256;
   localparam int CYCLE_LIMIT = 40000000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [1:0]                          req_type = ekmf_pkg::REQ_ADD;
   logic [ekmf_pkg::NODE_FW-1:0]        req_from_node = '0;
   logic [ekmf_pkg::NODE_FW-1:0]        req_to_node = '0;
   logic [ekmf_pkg::CAP_W-1:0]          req_capacity = '0;
   logic [ekmf_pkg::IDX_W-1:0]          req_edge_index = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_status;
   logic [ekmf_pkg::VAL_W-1:0]          rsp_value;
   logic [ekmf_pkg::NODE_FW-1:0]        rsp_edge_from;
   logic [ekmf_pkg::NODE_FW-1:0]        rsp_edge_to;
   logic                                csr_wr_en = 1'b0;
   logic [ekmf_pkg::CSR_IDX_W-1:0]      csr_index = ekmf_pkg::CSR_SOURCE;
   logic [ekmf_pkg::NODE_FW-1:0]        csr_wdata = '0;

   edmonds_karp_max_flow_unit dut (.*);

   always #5 clock = ~clock;

   // flow engine shadow state
   int unsigned                  res_cap [N*N];
   logic [ekmf_pkg::NODE_FW-1:0] edge_tail [E];
   logic [ekmf_pkg::NODE_FW-1:0] edge_head [E];
   int unsigned                  edge_total;
   logic [ekmf_pkg::NODE_FW-1:0] source_sel = ekmf_pkg::SOURCE_RST;
   logic [ekmf_pkg::NODE_FW-1:0] sink_sel = ekmf_pkg::SINK_RST;
   bit                           seen [N];
   int                           came_from [N];
   int                           bfs_order [N];

   ekmf_pkg::rsp_type pending_rsp [$];
   int                req_gap_pct = 0;
   int                rsp_stall_pct = 0;
   int                rsp_hold_req = 0;
   int                errors = 0;
   int                beats_sent = 0;
   int                beats_checked = 0;
   int                runs_sent = 0;
   longint            cycles = 0;

   function automatic void reach(int u, int v, inout int tl);
      if (!seen[v] && res_cap[u*N+v] > 0 && tl < N) begin
         seen[v] = 1'b1;
         came_from[v] = u;
         bfs_order[tl] = v;
         tl = tl + 1;
      end
   endfunction

   function automatic bit path_found(int s, int t);
      int hd;
      int tl;
      int u;
      hd = 0;
      tl = 1;
      foreach (seen[i]) seen[i] = 1'b0;
      seen[s] = 1'b1;
      came_from[s] = s;
      bfs_order[0] = s;
      while (hd < tl) begin
         u = bfs_order[hd];
         hd = hd + 1;
         if (u == t) break;
         for (int e = 0; e < edge_total; e++) begin
            if (edge_tail[e] == u) reach(u, edge_head[e], tl);
            if (edge_head[e] == u) reach(u, edge_tail[e], tl);
         end
      end
      return seen[t];
   endfunction

   function automatic int unsigned flow_total(int s, int t);
      int unsigned total;
      int unsigned neck;
      int unsigned back;
      int v;
      int u;
      total = 0;
      if (s == t) return 0;
      while (path_found(s, t)) begin
         neck = ekmf_pkg::RES_MAX;
         v = t;
         while (v != s) begin
            u = came_from[v];
            if (res_cap[u*N+v] < neck) neck = res_cap[u*N+v];
            v = u;
         end
         v = t;
         while (v != s) begin
            u = came_from[v];
            back = res_cap[v*N+u] + neck;
            res_cap[u*N+v] -= neck;
            res_cap[v*N+u] = (back > ekmf_pkg::RES_MAX) ? ekmf_pkg::RES_MAX : back;
            v = u;
         end
         total += neck;
         if (total > ekmf_pkg::VAL_MAX) total = ekmf_pkg::VAL_MAX;
      end
      return total;
   endfunction

   function automatic ekmf_pkg::rsp_type apply_req(ekmf_pkg::req_code_type op,
                                                   logic [ekmf_pkg::NODE_FW-1:0] a,
                                                   logic [ekmf_pkg::NODE_FW-1:0] b,
                                                   logic [ekmf_pkg::CAP_W-1:0] cap,
                                                   logic [ekmf_pkg::IDX_W-1:0] idx);
      ekmf_pkg::rsp_type r;
      r = '0;
      case (op)
         ekmf_pkg::REQ_ADD: begin
            if (edge_total >= E) begin
               r.status = 1'b1;
            end else begin
               res_cap[a*N+b] = 32'(cap);
               edge_tail[edge_total] = a;
               edge_head[edge_total] = b;
               edge_total++;
            end
         end
         ekmf_pkg::REQ_RUN: r.value = ekmf_pkg::VAL_W'(flow_total(source_sel, sink_sel));
         ekmf_pkg::REQ_READ: begin
            if (idx >= edge_total) begin
               r.status = 1'b1;
            end else begin
               r.edge_from = edge_tail[idx];
               r.edge_to = edge_head[idx];
               r.value = ekmf_pkg::VAL_W'(res_cap[edge_head[idx]*N + edge_tail[idx]]);
            end
         end
         default: begin
            foreach (res_cap[i]) res_cap[i] = 0;
            edge_total = 0;
         end
      endcase
      return r;
   endfunction

   task automatic send_req(ekmf_pkg::req_code_type op,
                           logic [ekmf_pkg::NODE_FW-1:0] a = '0,
                           logic [ekmf_pkg::NODE_FW-1:0] b = '0,
                           logic [ekmf_pkg::CAP_W-1:0] cap = '0,
                           logic [ekmf_pkg::IDX_W-1:0] idx = '0);
      ekmf_pkg::rsp_type exp_rsp;
      exp_rsp = apply_req(op, a, b, cap, idx);
      pending_rsp = {pending_rsp, exp_rsp};
      @(negedge clock);
      while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_from_node <= a;
      req_to_node <= b;
      req_capacity <= cap;
      req_edge_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if (op == ekmf_pkg::REQ_RUN) runs_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(ekmf_pkg::csr_reg_type r, logic [ekmf_pkg::NODE_FW-1:0] d);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= r;
      csr_wdata <= d;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (r == ekmf_pkg::CSR_SOURCE) source_sel = d;
      else sink_sel = d;
   endtask

   task automatic set_ends(logic [ekmf_pkg::NODE_FW-1:0] s, logic [ekmf_pkg::NODE_FW-1:0] t);
      drain();
      csr_write(ekmf_pkg::CSR_SOURCE, s);
      csr_write(ekmf_pkg::CSR_SINK, t);
   endtask

   // extremes, antiparallel edges, self loop, reverse saturation, empty graph
   task automatic test_directed();
      set_ends(6'd0, 6'd1);
      send_req(ekmf_pkg::REQ_READ, 0, 0, 0, 8'd0);
      send_req(ekmf_pkg::REQ_RUN);
      send_req(ekmf_pkg::REQ_ADD, 6'd0, 6'd1, 16'hFFFF);
      send_req(ekmf_pkg::REQ_ADD, 6'd1, 6'd0, 16'hFFFF);
      send_req(ekmf_pkg::REQ_ADD, 6'd63, 6'd63, 16'hFFFF);
      send_req(ekmf_pkg::REQ_ADD, 6'd0, 6'd42, 16'd1);
      send_req(ekmf_pkg::REQ_ADD, 6'd42, 6'd1, 16'hAAAA);
      send_req(ekmf_pkg::REQ_ADD, 6'd21, 6'd1, 16'h5555);
      send_req(ekmf_pkg::REQ_RUN);
      send_req(ekmf_pkg::REQ_READ, 0, 0, 0, 8'd0);
      send_req(ekmf_pkg::REQ_ADD, 6'd0, 6'd1, 16'hFFFF);
      send_req(ekmf_pkg::REQ_RUN);
      send_req(ekmf_pkg::REQ_ADD, 6'd0, 6'd1, 16'hFFFF);
      send_req(ekmf_pkg::REQ_RUN);
      send_req(ekmf_pkg::REQ_READ, 0, 0, 0, 8'd0);
      send_req(ekmf_pkg::REQ_READ, 0, 0, 0, 8'd2);
      send_req(ekmf_pkg::REQ_READ, 0, 0, 0, 8'd255);
      send_req(ekmf_pkg::REQ_ADD, 6'd0, 6'd0, 16'd0);
      send_req(ekmf_pkg::REQ_RUN);
      set_ends(6'd63, 6'd63);
      send_req(ekmf_pkg::REQ_RUN);
      send_req(ekmf_pkg::REQ_CLEAR);
      send_req(ekmf_pkg::REQ_RUN);
      send_req(ekmf_pkg::REQ_READ, 0, 0, 0, 8'd0);
      drain();
   endtask

   task automatic test_table_full();
      set_ends(6'd5, 6'd5);
      for (int i = 0; i < E; i++)
         send_req(ekmf_pkg::REQ_ADD, 6'($urandom), 6'($urandom), 16'($urandom));
      send_req(ekmf_pkg::REQ_ADD, 6'd3, 6'd4, 16'd7);
      send_req(ekmf_pkg::REQ_READ, 0, 0, 0, 8'd255);
      send_req(ekmf_pkg::REQ_READ, 0, 0, 0, 8'($urandom));
      send_req(ekmf_pkg::REQ_RUN);
      send_req(ekmf_pkg::REQ_CLEAR);
      drain();
   endtask

   // receiver holds off while the sender keeps pushing beats
   task automatic test_backpressure();
      rsp_hold_req = 600;
      for (int i = 0; i < 20; i++)
         send_req(ekmf_pkg::REQ_ADD, 6'($urandom_range(0, 7)), 6'($urandom_range(0, 7)),
                  16'($urandom));
      send_req(ekmf_pkg::REQ_CLEAR);
      drain();
   endtask

   task automatic test_random_phase(int gap_pct, int stall_pct,
                                    logic [ekmf_pkg::NODE_FW-1:0] s,
                                    logic [ekmf_pkg::NODE_FW-1:0] t, int count);
      logic [ekmf_pkg::NODE_FW-1:0] pool [8];
      int r;
      set_ends(s, t);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      pool[0] = s;
      pool[1] = t;
      for (int i = 2; i < 8; i++) pool[i] = 6'($urandom);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (edge_total >= 24) send_req(ekmf_pkg::REQ_CLEAR);
         else if (r < 50)
            send_req(ekmf_pkg::REQ_ADD, pool[$urandom_range(0, 7)],
                     pool[$urandom_range(0, 7)], 16'($urandom));
         else if (r < 55)
            send_req(ekmf_pkg::REQ_ADD, 6'($urandom), 6'($urandom), 16'($urandom));
         else if (r < 72) send_req(ekmf_pkg::REQ_RUN);
         else if (r < 92)
            send_req(ekmf_pkg::REQ_READ, 0, 0, 0, 8'($urandom_range(0, edge_total + 2)));
         else if (r < 98)
            send_req(ekmf_pkg::req_code_type'(2'($urandom)), 6'($urandom), 6'($urandom),
                     16'($urandom), 8'($urandom));
         else send_req(ekmf_pkg::REQ_CLEAR);
      end
      drain();
      req_gap_pct = 0;
      rsp_stall_pct = 0;
   endtask

   always @(negedge clock) begin
      static int hold_left = 0;
      if (rsp_hold_req != 0) begin
         hold_left = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      ekmf_pkg::rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            beats_checked++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_value);
               errors++;
            end
            if (rsp_edge_from !== want.edge_from) begin
               $error("edge_from: expected %0d, got %0d", want.edge_from, rsp_edge_from);
               errors++;
            end
            if (rsp_edge_to !== want.edge_to) begin
               $error("edge_to: expected %0d, got %0d", want.edge_to, rsp_edge_to);
               errors++;
            end
         end
      end
   end

   initial begin
      foreach (res_cap[i]) res_cap[i] = 0;
      edge_total = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_backpressure();
      test_random_phase(0, 0, 6'd0, 6'd63, 75);
      test_random_phase(69, 0, 6'd63, 6'd0, 75);
      test_random_phase(0, 69, 6'($urandom), 6'($urandom), 75);
      test_random_phase(34, 34, 6'($urandom), 6'($urandom), 75);
      if (pending_rsp.size() != 0) begin
         $error("%0d results never arrived", pending_rsp.size());
         errors++;
      end
      $display("Covered %0d request beats (%0d flow runs), %0d results checked, %0d errors.",
               beats_sent, runs_sent, beats_checked, errors);
      $display("Phases: directed, full edge table, output stall, four idle mixes.");
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
